[src/hss_pkg.sv]
package hss_pkg;

	localparam int GC_W   = 6;
	localparam int COEF_W = 15;
	localparam int CFG_W  = 15;
	localparam int VAL_W  = 32;
	localparam int GC_MIN = 3;

	localparam logic [GC_W-1:0]   GC_RESET   = 6'd32;
	localparam logic [COEF_W-1:0] COEF_RESET = 15'd4096;

	localparam logic signed [17:0]      ONE_Q16  = 18'sd65536;
	localparam int                      HALF_Q16 = 32768;
	localparam logic signed [VAL_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN  = 32'sh8000_0000;

	typedef enum logic [0:0] {
		REG_GRID_COLUMNS    = 1'b0,
		REG_DIFFUSION_COEFF = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_STREAM,
		ST_PRIME0,
		ST_PRIME1,
		ST_DRAIN
	} seq_state_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] cell_value;
		logic                    frame_end;
	} cell_in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] new_value;
		logic                    last_out;
	} cell_out_t;

endpackage

[src/heat_stencil_sweep_core.sv]
// One explicit heat-diffusion time step over a grid streamed in row-major order.
// cell_* carries one grid cell per transfer (valid/ready); frame_end marks the
// last cell of the grid. result_* returns updated cells in row-major order, one
// per transfer; last_out marks the final cell. Each result appears when the cell
// below it arrives; that input transfer loads stage one, and two more stages and
// the output register follow before result_valid rises. Throughput: one cell per
// cycle while streaming, unless result_ready stalls the pipeline. A frame_end
// transfer starts a drain of up to grid_columns results (cell_ready low), one per
// cycle unless stalled, read back from the history memory. A write of grid_columns
// holds cell_ready low in ST_PRIME0/1 while the stencil taps are reloaded from memory.
// The history memory has one write port and two read ports; its two reads per
// cell set the one-cell-per-cycle rate.
// When the receiver stalls, the pipeline fills its bubbles and keeps taking
// cells until every stage is occupied, then holds cell_ready low.
// arst_n clears the pipeline, counters and registers (grid_columns = 32,
// diffusion_coeff = 4096); history memory contents are undefined until written.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// are expected only while the block is idle.
module heat_stencil_sweep_core #(
	parameter int MAX_COLS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cell_valid,
	output logic                           cell_ready,
	input  hss_pkg::cell_in_t              cell_data,
	output logic                           result_valid,
	input  logic                           result_ready,
	output hss_pkg::cell_out_t             result_data,
	input  logic                           cfg_we,
	input  hss_pkg::reg_idx_t              cfg_index,
	input  logic [hss_pkg::CFG_W-1:0]      cfg_wdata
);

	localparam int NW    = $clog2(MAX_COLS + 1);
	localparam int PTR_W = $clog2(2 * MAX_COLS);
	localparam int DEPTH = 2 ** PTR_W;
	localparam logic [1:0] ROWS_SAT = 2'd2;

	logic [hss_pkg::GC_W-1:0]   grid_columns_q;
	logic [hss_pkg::COEF_W-1:0] coeff_q;

	hss_pkg::seq_state_t state_q, state_d;

	logic [NW-1:0]    n_used, n_m1, col_q, col_inc, drain_q, drain_first;
	logic [PTR_W-1:0] n_p, wr_ptr_q, addr_a, addr_b;
	logic [1:0]       rows_q;

	logic signed [hss_pkg::VAL_W-1:0] row_store [DEPTH];
	logic signed [hss_pkg::VAL_W-1:0] rd_a_q, rd_b_q, win_c_q, win_l_q;

	logic en_out, en3, en2, en1, accept;
	logic rd_a_en, rd_b_en, slot_v, slot_drain, slot_last, slot_interior;

	logic                             v1_q, interior_s1, drain_s1, last_s1;
	logic signed [hss_pkg::VAL_W-1:0] down_s1, centre1;
	logic signed [33:0]               sum1;

	logic                             v2_q, interior_s2, last_s2;
	logic signed [hss_pkg::VAL_W-1:0] centre_s2;
	logic signed [33:0]               sum_s2;
	logic signed [17:0]               wc;
	logic signed [49:0]               p0, p1;

	logic                             v3_q, interior_s3, last_s3;
	logic signed [hss_pkg::VAL_W-1:0] pass_s3, sat3;
	logic signed [49:0]               p0_s3, p1_s3;
	logic signed [51:0]               acc3;
	logic signed [35:0]               q3;

	logic               result_valid_q;
	hss_pkg::cell_out_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= hss_pkg::GC_RESET;
			coeff_q        <= hss_pkg::COEF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hss_pkg::REG_GRID_COLUMNS:    grid_columns_q <= cfg_wdata[hss_pkg::GC_W-1:0];
				hss_pkg::REG_DIFFUSION_COEFF: coeff_q <= cfg_wdata[hss_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (grid_columns_q < hss_pkg::GC_W'(hss_pkg::GC_MIN)) begin
			n_used = NW'(hss_pkg::GC_MIN);
		end else if (grid_columns_q > hss_pkg::GC_W'(MAX_COLS)) begin
			n_used = NW'(MAX_COLS);
		end else begin
			n_used = NW'(grid_columns_q);
		end
	end

	assign n_m1    = n_used - NW'(1);
	assign n_p     = PTR_W'(n_used);
	assign col_inc = col_q + NW'(1);

	assign en_out = !result_valid_q || result_ready;
	assign en3    = !v3_q || en_out;
	assign en2    = !v2_q || en3;
	assign en1    = !v1_q || en2;
	assign accept = cell_valid && en1 && (state_q == hss_pkg::ST_STREAM);

	assign slot_interior = rows_q[1] && (col_q != '0)
		&& (({1'b0, col_q} + (NW + 1)'(2)) <= {1'b0, n_used});

	always_comb begin
		if (rows_q != '0) begin
			drain_first = n_m1;
		end else if (col_q > n_m1) begin
			drain_first = n_m1;
		end else begin
			drain_first = col_q;
		end
	end

	always_comb begin
		state_d = state_q;
		if (cfg_we && cfg_index == hss_pkg::REG_GRID_COLUMNS) begin
			state_d = hss_pkg::ST_PRIME0;
		end else if (en1) begin
			unique case (state_q)
				hss_pkg::ST_STREAM: begin
					if (accept && cell_data.frame_end) state_d = hss_pkg::ST_DRAIN;
				end
				hss_pkg::ST_PRIME0: state_d = hss_pkg::ST_PRIME1;
				hss_pkg::ST_PRIME1: state_d = hss_pkg::ST_STREAM;
				hss_pkg::ST_DRAIN: begin
					if (drain_q == '0) state_d = hss_pkg::ST_STREAM;
				end
				default: state_d = hss_pkg::ST_STREAM;
			endcase
		end
	end

	always_comb begin
		cell_ready = 1'b0;
		rd_a_en    = 1'b0;
		rd_b_en    = 1'b0;
		addr_a     = wr_ptr_q - n_p + PTR_W'(1);
		addr_b     = wr_ptr_q - (n_p << 1);
		slot_v     = 1'b0;
		slot_drain = 1'b0;
		slot_last  = 1'b0;
		unique case (state_q)
			hss_pkg::ST_STREAM: begin
				cell_ready = en1;
				rd_a_en    = accept;
				rd_b_en    = accept;
				slot_v     = accept && (rows_q != '0);
			end
			hss_pkg::ST_PRIME0: begin
				rd_a_en = en1;
				addr_a  = wr_ptr_q - n_p - PTR_W'(1);
			end
			hss_pkg::ST_PRIME1: begin
				rd_a_en = en1;
				addr_a  = wr_ptr_q - n_p;
			end
			hss_pkg::ST_DRAIN: begin
				rd_a_en    = en1;
				addr_a     = wr_ptr_q - PTR_W'(1) - PTR_W'(drain_q);
				slot_v     = en1;
				slot_drain = 1'b1;
				slot_last  = (drain_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hss_pkg::ST_STREAM;
			wr_ptr_q <= '0;
			col_q    <= '0;
			rows_q   <= '0;
			drain_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
				if (cell_data.frame_end) begin
					col_q   <= '0;
					rows_q  <= '0;
					drain_q <= drain_first;
				end else if (col_inc >= n_used) begin
					col_q <= '0;
					if (rows_q != ROWS_SAT) rows_q <= rows_q + 2'd1;
				end else begin
					col_q <= col_inc;
				end
			end
			if (state_q == hss_pkg::ST_DRAIN && en1 && drain_q != '0) begin
				drain_q <= drain_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) row_store[wr_ptr_q] <= cell_data.cell_value;
		if (rd_a_en) begin
			rd_a_q  <= row_store[addr_a];
			win_c_q <= rd_a_q;
			win_l_q <= win_c_q;
		end
		if (rd_b_en) rd_b_q <= row_store[addr_b];
	end

	// valid flags for every stage, then stage 1: taps ready, sum neighbours
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (en1) v1_q <= slot_v;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en_out) result_valid_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			interior_s1 <= slot_interior && !slot_drain;
			drain_s1    <= slot_drain;
			last_s1     <= slot_last;
			down_s1     <= cell_data.cell_value;
		end
	end

	assign centre1 = drain_s1 ? rd_a_q : win_c_q;
	assign sum1    = 34'(rd_b_q) + 34'(down_s1) + 34'(win_l_q) + 34'(rd_a_q);

	// stage 2: weight products
	always_ff @(posedge clk) begin
		if (en2) begin
			interior_s2 <= interior_s1;
			last_s2     <= last_s1;
			centre_s2   <= centre1;
			sum_s2      <= sum1;
		end
	end

	assign wc = hss_pkg::ONE_Q16 - $signed({1'b0, coeff_q, 2'b00});
	assign p0 = wc * centre_s2;
	assign p1 = $signed({1'b0, coeff_q}) * sum_s2;

	// stage 3: round and saturate
	always_ff @(posedge clk) begin
		if (en3) begin
			interior_s3 <= interior_s2;
			last_s3     <= last_s2;
			pass_s3     <= centre_s2;
			p0_s3       <= p0;
			p1_s3       <= p1;
		end
	end

	assign acc3 = 52'(p0_s3) + 52'(p1_s3) + 52'(hss_pkg::HALF_Q16);
	assign q3   = acc3[51:16];

	always_comb begin
		if (!q3[35] && q3[34:31] != 4'h0) begin
			sat3 = hss_pkg::VAL_MAX;
		end else if (q3[35] && q3[34:31] != 4'hF) begin
			sat3 = hss_pkg::VAL_MIN;
		end else begin
			sat3 = q3[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			result_q.new_value <= interior_s3 ? sat3 : pass_s3;
			result_q.last_out  <= last_s3;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

[src/hss_checker.sv]
module hss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cell_valid,
	input logic               cell_ready,
	input hss_pkg::cell_in_t  cell_data,
	input logic               result_valid,
	input logic               result_ready,
	input hss_pkg::cell_out_t result_data,
	input logic               cfg_we,
	input hss_pkg::reg_idx_t  cfg_index
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result dropped or changed while stalled");

	a_drain_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && cell_ready && cell_data.frame_end |=> !cell_ready)
		else $error("cell taken during drain");

	a_prime_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == hss_pkg::REG_GRID_COLUMNS |=> !cell_ready ##1 !cell_ready)
		else $error("cell taken before taps reloaded");

endmodule

bind heat_stencil_sweep_core hss_checker u_hss_checker (.*);
